// File: rtl/core/hsv_rgb_color_converter_defines.svh
// Assertion macros for the HSV/RGB colour converter.
`ifndef HSV_RGB_COLOR_CONVERTER_DEFINES_SVH
`define HSV_RGB_COLOR_CONVERTER_DEFINES_SVH
`ifndef SYNTHESIS
`define HRC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hrc assertion failed");
`define HRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hrc assertion failed");
`else
`define HRC_ASSERT_NOW(lbl, ante, cons)
`define HRC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/core/hrc_pkg.sv
// Shared types and constants of the HSV/RGB colour converter.
`default_nettype none
package hrc_pkg;
  localparam int HUE_W      = 14;
  localparam int LANES      = 3;
  localparam int HUE_POS_LIM = 8191;
  localparam int HUE_NEG_LIM = 8192;
  localparam int TURN_DEG   = 360;
  localparam int SIXTH_DEG  = 60;
  localparam int HALF_DEG   = 180;
  localparam int BASE_GREEN = 85;
  localparam int BASE_BLUE  = 171;
  localparam int SECT_SPAN  = 43;
  localparam int SECT_SCALE = 255;
  localparam int OFF_GREEN  = 4;
  localparam int OFF_BLUE   = 2;
  localparam logic CMD_RGB2HSV = 1'b0;
  localparam logic CMD_HSV2RGB = 1'b1;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;
endpackage
`default_nettype wire

// File: rtl/core/hrc_in_if.sv
// Input channel of the converter: valid, ready and one pixel beat.
`default_nettype none
interface hrc_in_if #(
  parameter int CB = 12
);
  logic                            valid;
  logic                            ready;
  logic                            cmd;
  logic [CB-1:0]                   red_in;
  logic [CB-1:0]                   green_in;
  logic [CB-1:0]                   blue_in;
  logic signed [hrc_pkg::HUE_W-1:0] hue_in;
  logic [CB-1:0]                   sat_in;
  logic [CB-1:0]                   val_in;

  modport source (output valid, cmd, red_in, green_in, blue_in, hue_in, sat_in, val_in,
                  input ready);
  modport sink (input valid, cmd, red_in, green_in, blue_in, hue_in, sat_in, val_in,
                output ready);
endinterface
`default_nettype wire

// File: rtl/core/hrc_out_if.sv
// Result channel of the converter: valid, ready and one result beat.
`default_nettype none
interface hrc_out_if #(
  parameter int CB = 12
);
  logic                            valid;
  logic                            ready;
  logic [CB-1:0]                   red_out;
  logic [CB-1:0]                   green_out;
  logic [CB-1:0]                   blue_out;
  logic signed [hrc_pkg::HUE_W-1:0] hue_out;
  logic [CB-1:0]                   sat_out;
  logic [CB-1:0]                   val_out;

  modport source (output valid, red_out, green_out, blue_out, hue_out, sat_out, val_out,
                  input ready);
  modport sink (input valid, red_out, green_out, blue_out, hue_out, sat_out, val_out,
                output ready);
endinterface
`default_nettype wire

// File: rtl/core/hrc_div.sv
// Pipelined restoring divider, three lanes, one quotient bit per stage.
`default_nettype none
module hrc_div #(
  parameter int NW  = 48,
  parameter int DVW = 32,
  parameter int QW  = 13,
  parameter int SW  = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [NW-1:0]  in_num  [hrc_pkg::LANES],
  input  logic [DVW-1:0] in_den  [hrc_pkg::LANES],
  input  logic [SW-1:0]  in_side,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [QW-1:0]  out_quo [hrc_pkg::LANES],
  output logic [SW-1:0]  out_side
);
  localparam int CW = (NW > DVW + QW) ? NW : DVW + QW;

  logic           vld  [QW];
  logic           en   [QW+1];
  logic [NW-1:0]  rem  [QW][hrc_pkg::LANES];
  logic [DVW-1:0] den  [QW][hrc_pkg::LANES];
  logic [QW-1:0]  quo  [QW][hrc_pkg::LANES];
  logic [SW-1:0]  side [QW];

  assign en[QW]    = out_ready;
  assign in_ready  = en[0];
  assign out_valid = vld[QW-1];
  assign out_quo   = quo[QW-1];
  assign out_side  = side[QW-1];

  for (genvar s = 0; s < QW; s++) begin : g_stg
    localparam int K = QW - 1 - s;
    logic           vp;
    logic [NW-1:0]  rp [hrc_pkg::LANES];
    logic [DVW-1:0] dp [hrc_pkg::LANES];
    logic [QW-1:0]  qp [hrc_pkg::LANES];
    logic [SW-1:0]  sp;
    logic [NW-1:0]  rem_nxt [hrc_pkg::LANES];
    logic [QW-1:0]  quo_nxt [hrc_pkg::LANES];
    logic           vld_r;
    logic [NW-1:0]  rem_r [hrc_pkg::LANES];
    logic [DVW-1:0] den_r [hrc_pkg::LANES];
    logic [QW-1:0]  quo_r [hrc_pkg::LANES];
    logic [SW-1:0]  side_r;

    if (s == 0) begin : g_first
      assign vp = in_valid;
      assign rp = in_num;
      assign dp = in_den;
      assign sp = in_side;
      for (genvar l = 0; l < hrc_pkg::LANES; l++) begin : g_q0
        assign qp[l] = '0;
      end
    end else begin : g_next
      assign vp = vld[s-1];
      assign rp = rem[s-1];
      assign dp = den[s-1];
      assign qp = quo[s-1];
      assign sp = side[s-1];
    end

    always_comb begin
      logic [CW-1:0] trial;
      for (int l = 0; l < hrc_pkg::LANES; l++) begin
        trial = CW'(dp[l]) << K;
        rem_nxt[l] = rp[l];
        quo_nxt[l] = qp[l];
        if (CW'(rp[l]) >= trial) begin
          rem_nxt[l] = NW'(CW'(rp[l]) - trial);
          quo_nxt[l] = qp[l] | (QW'(1) << K);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en[s]) begin
        vld_r <= vp;
      end
      if (en[s]) begin
        rem_r  <= rem_nxt;
        den_r  <= dp;
        quo_r  <= quo_nxt;
        side_r <= sp;
      end
    end

    assign en[s]   = !vld_r || en[s+1];
    assign vld[s]  = vld_r;
    assign rem[s]  = rem_r;
    assign den[s]  = den_r;
    assign quo[s]  = quo_r;
    assign side[s] = side_r;
  end
endmodule
`default_nettype wire

// File: rtl/core/hsv_rgb_color_converter.sv
// HSV/RGB colour converter: streaming pipeline, one pixel beat per cycle unless back-pressure stalls it.
//
// Each beat is converted on its own: cmd 1 turns hue, saturation and value into
// RGB, cmd 0 turns RGB into hue, saturation and value; the fields of the other
// direction read zero. A beat can enter every cycle unless back-pressure stalls
// the pipeline. Five front stages wrap the hue, find the extremes and form the
// products, a restoring divider then resolves one quotient bit per stage for
// all three lanes, and a last stage applies the sign, clamps the hue and
// registers the result. Back-pressure collapses bubbles stage by stage.
`default_nettype none
`include "hsv_rgb_color_converter_defines.svh"
module hsv_rgb_color_converter #(
  parameter int CHANNEL_BITS  = 12,
  parameter int HUE_FRAC_BITS = 4
) (
  input  logic   clk,
  input  logic   rst_n,
  hrc_in_if.sink    in_ch,
  hrc_out_if.source out_ch
);
  localparam int CB = CHANNEL_BITS;
  localparam int F  = HUE_FRAC_BITS;
  localparam int HUW = hrc_pkg::HUE_W;
  localparam longint MAXC = (longint'(1) << CB) - 1;
  localparam longint H    = longint'(hrc_pkg::TURN_DEG) << F;
  localparam longint D    = longint'(hrc_pkg::SIXTH_DEG) << F;
  localparam longint HALF = longint'(hrc_pkg::HALF_DEG) << F;
  localparam longint HIN  = longint'(1) << (HUW - 1);
  localparam int HW   = $clog2(H);
  localparam int EW   = $clog2(D + 1);
  localparam longint DEN = MAXC * D;
  localparam int DENW = $clog2(DEN + 1);
  localparam int PW   = CB + DENW;
  localparam int CSW  = CB + 9;
  localparam int HABW = CB + 17;
  localparam int CH_NW  = PW + 1;
  localparam int SAT_NW = 2 * CB + 2;
  localparam int HUE_NW = HABW + F + 2;
  localparam int NW0 = (CH_NW > SAT_NW) ? CH_NW : SAT_NW;
  localparam int NW  = (NW0 > HUE_NW) ? NW0 : HUE_NW;
  localparam int DVW = (DENW > CB + 9) ? DENW : CB + 9;
  localparam int QW  = (CB > HW) ? CB : HW;
  localparam int MW  = ((QW > HUW) ? QW : HUW) + 1;
  localparam longint WRAP_C = (H - (HIN % H)) % H;
  localparam int XW = $clog2(2 * HIN + H);
  localparam int NQ = $clog2((2 * HIN - 1 + H) / H + 1);
  localparam int AW = (XW > HW + NQ) ? XW : HW + NQ;

  typedef struct packed {
    logic          cmd;
    logic          blk;
    logic          gry;
    logic          hneg;
    logic [CB-1:0] val;
  } side_t;

  logic en_a, en_b, en_c, en_d, en_e, en_f;
  logic div_in_ready, div_out_valid;
  logic [QW-1:0] div_quo [hrc_pkg::LANES];
  side_t div_side;

  // Stage A: wrap hue, find extremes and sector
  logic                 va_r, cmd_a_r;
  logic [HW-1:0]        hw_a_r, hw_a_nxt;
  logic [CB-1:0]        s_a_r, v_a_r, mx_a_r, mn_a_r, mx_a_nxt, mn_a_nxt;
  hrc_pkg::sector_t     sec_a_r, sec_a_nxt;
  logic signed [CB:0]   nd_a_r, nd_a_nxt;

  always_comb begin
    logic [AW-1:0] acc;
    logic [CB-1:0] r, g, b;
    r = in_ch.red_in;
    g = in_ch.green_in;
    b = in_ch.blue_in;
    acc = AW'({~in_ch.hue_in[HUW-1], in_ch.hue_in[HUW-2:0]}) + AW'(WRAP_C);
    for (int k = NQ - 1; k >= 0; k--) begin
      if (acc >= (AW'(H) << k)) begin
        acc = acc - (AW'(H) << k);
      end
    end
    hw_a_nxt = HW'(acc);
    if (r >= g && r >= b) begin
      sec_a_nxt = hrc_pkg::SEC_RED;
      mx_a_nxt  = r;
      nd_a_nxt  = $signed({1'b0, g}) - $signed({1'b0, b});
    end else if (g >= b) begin
      sec_a_nxt = hrc_pkg::SEC_GREEN;
      mx_a_nxt  = g;
      nd_a_nxt  = $signed({1'b0, b}) - $signed({1'b0, r});
    end else begin
      sec_a_nxt = hrc_pkg::SEC_BLUE;
      mx_a_nxt  = b;
      nd_a_nxt  = $signed({1'b0, r}) - $signed({1'b0, g});
    end
    mn_a_nxt = r;
    if (g < mn_a_nxt) mn_a_nxt = g;
    if (b < mn_a_nxt) mn_a_nxt = b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en_a) begin
      va_r <= in_ch.valid;
    end
    if (en_a) begin
      cmd_a_r <= in_ch.cmd;
      hw_a_r  <= hw_a_nxt;
      s_a_r   <= in_ch.sat_in;
      v_a_r   <= in_ch.val_in;
      mx_a_r  <= mx_a_nxt;
      mn_a_r  <= mn_a_nxt;
      sec_a_r <= sec_a_nxt;
      nd_a_r  <= nd_a_nxt;
    end
  end

  // Stage B: triangle wave per channel, sector numerator
  logic                  vb_r, cmd_b_r;
  logic [EW-1:0]         e_b_r [hrc_pkg::LANES];
  logic [EW-1:0]         e_b_nxt [hrc_pkg::LANES];
  logic [CB-1:0]         s_b_r, v_b_r, mx_b_r, dl_b_r, dl_b_nxt;
  logic signed [CSW-1:0] cs_b_r, cs_b_nxt;

  always_comb begin
    logic [HW:0]   t, offv;
    logic [HW-1:0] a;
    logic [CSW-1:0] basev;
    logic signed [CSW-1:0] bd, n43;
    for (int l = 0; l < hrc_pkg::LANES; l++) begin
      if (l == 1) begin
        offv = (HW+1)'(D * hrc_pkg::OFF_GREEN);
      end else if (l == 2) begin
        offv = (HW+1)'(D * hrc_pkg::OFF_BLUE);
      end else begin
        offv = '0;
      end
      t = (HW+1)'(hw_a_r) + offv;
      if (t >= (HW+1)'(H)) t = t - (HW+1)'(H);
      if (t >= (HW+1)'(HALF)) begin
        a = HW'(t - (HW+1)'(HALF));
      end else begin
        a = HW'((HW+1)'(HALF) - t);
      end
      if (a <= HW'(D)) begin
        e_b_nxt[l] = EW'(D);
      end else if (a >= HW'(2 * D)) begin
        e_b_nxt[l] = '0;
      end else begin
        e_b_nxt[l] = EW'(HW'(2 * D) - a);
      end
    end
    dl_b_nxt = mx_a_r - mn_a_r;
    unique case (sec_a_r)
      hrc_pkg::SEC_GREEN: basev = CSW'(hrc_pkg::BASE_GREEN);
      hrc_pkg::SEC_BLUE:  basev = CSW'(hrc_pkg::BASE_BLUE);
      default:            basev = '0;
    endcase
    bd = $signed(CSW'(dl_b_nxt) * basev);
    n43 = CSW'(nd_a_r) * CSW'(hrc_pkg::SECT_SPAN);
    cs_b_nxt = bd + n43;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en_b) begin
      vb_r <= va_r;
    end
    if (en_b) begin
      cmd_b_r <= cmd_a_r;
      e_b_r   <= e_b_nxt;
      s_b_r   <= s_a_r;
      v_b_r   <= v_a_r;
      mx_b_r  <= mx_a_r;
      dl_b_r  <= dl_b_nxt;
      cs_b_r  <= cs_b_nxt;
    end
  end

  // Stage C: saturation products, hue magnitude
  logic                 vc_r, cmd_c_r, hneg_c_r;
  logic [CB+EW-1:0]     se_c_r [hrc_pkg::LANES];
  logic [CB+EW-1:0]     se_c_nxt [hrc_pkg::LANES];
  logic [HABW-1:0]      hab_c_r, hab_c_nxt;
  logic [CB-1:0]        v_c_r, mx_c_r, dl_c_r;

  always_comb begin
    logic [CSW-1:0] mag;
    for (int l = 0; l < hrc_pkg::LANES; l++) begin
      se_c_nxt[l] = (CB+EW)'(s_b_r) * (CB+EW)'(e_b_r[l]);
    end
    mag = cs_b_r[CSW-1] ? CSW'(-cs_b_r) : CSW'(cs_b_r);
    hab_c_nxt = HABW'(mag) * HABW'(hrc_pkg::TURN_DEG);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en_c) begin
      vc_r <= vb_r;
    end
    if (en_c) begin
      cmd_c_r  <= cmd_b_r;
      hneg_c_r <= cs_b_r[CSW-1];
      se_c_r   <= se_c_nxt;
      hab_c_r  <= hab_c_nxt;
      v_c_r    <= v_b_r;
      mx_c_r   <= mx_b_r;
      dl_c_r   <= dl_b_r;
    end
  end

  // Stage D: scale by value
  logic              vd_r, cmd_d_r, hneg_d_r;
  logic [PW-1:0]     pch_d_r [hrc_pkg::LANES];
  logic [PW-1:0]     pch_d_nxt [hrc_pkg::LANES];
  logic [HABW-1:0]   hab_d_r;
  logic [CB-1:0]     mx_d_r, dl_d_r;

  always_comb begin
    for (int l = 0; l < hrc_pkg::LANES; l++) begin
      pch_d_nxt[l] = PW'(v_c_r) * PW'(DENW'(DEN) - DENW'(se_c_r[l]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (en_d) begin
      vd_r <= vc_r;
    end
    if (en_d) begin
      cmd_d_r  <= cmd_c_r;
      hneg_d_r <= hneg_c_r;
      pch_d_r  <= pch_d_nxt;
      hab_d_r  <= hab_c_r;
      mx_d_r   <= mx_c_r;
      dl_d_r   <= dl_c_r;
    end
  end

  // Stage E: dividends and divisors with rounding terms
  logic           ve_r;
  logic [NW-1:0]  num_e_r [hrc_pkg::LANES];
  logic [NW-1:0]  num_e_nxt [hrc_pkg::LANES];
  logic [DVW-1:0] den_e_r [hrc_pkg::LANES];
  logic [DVW-1:0] den_e_nxt [hrc_pkg::LANES];
  side_t          side_e_r, side_e_nxt;

  always_comb begin
    side_e_nxt.cmd  = cmd_d_r;
    side_e_nxt.blk  = (mx_d_r == '0);
    side_e_nxt.gry  = (dl_d_r == '0);
    side_e_nxt.hneg = hneg_d_r;
    side_e_nxt.val  = mx_d_r;
    if (cmd_d_r == hrc_pkg::CMD_HSV2RGB) begin
      for (int l = 0; l < hrc_pkg::LANES; l++) begin
        num_e_nxt[l] = NW'(pch_d_r[l]) + NW'(DEN / 2);
        den_e_nxt[l] = DVW'(DEN);
      end
    end else begin
      num_e_nxt[0] = (((NW'(dl_d_r) << CB) - NW'(dl_d_r)) << 1) + NW'(mx_d_r);
      den_e_nxt[0] = DVW'(mx_d_r) << 1;
      num_e_nxt[1] = (NW'(hab_d_r) << (F + 1))
                   + NW'(dl_d_r) * NW'(hrc_pkg::SECT_SCALE);
      den_e_nxt[1] = DVW'(dl_d_r) * DVW'(2 * hrc_pkg::SECT_SCALE);
      num_e_nxt[2] = '0;
      den_e_nxt[2] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (en_e) begin
      ve_r <= vd_r;
    end
    if (en_e) begin
      num_e_r  <= num_e_nxt;
      den_e_r  <= den_e_nxt;
      side_e_r <= side_e_nxt;
    end
  end

  hrc_div #(
    .NW  (NW),
    .DVW (DVW),
    .QW  (QW),
    .SW  ($bits(side_t))
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ve_r),
    .in_ready  (div_in_ready),
    .in_num    (num_e_r),
    .in_den    (den_e_r),
    .in_side   (side_e_r),
    .out_valid (div_out_valid),
    .out_ready (en_f),
    .out_quo   (div_quo),
    .out_side  (div_side)
  );

  // Stage F: sign, clamp and zero the unused direction
  logic                  vf_r;
  logic [CB-1:0]         red_f_r, grn_f_r, blu_f_r, sat_f_r, val_f_r;
  logic [CB-1:0]         red_f_nxt, grn_f_nxt, blu_f_nxt, sat_f_nxt, val_f_nxt;
  logic signed [HUW-1:0] hue_f_r, hue_f_nxt;

  always_comb begin
    logic [MW-1:0] magx;
    magx = MW'(div_quo[1]);
    red_f_nxt = '0;
    grn_f_nxt = '0;
    blu_f_nxt = '0;
    sat_f_nxt = '0;
    val_f_nxt = '0;
    hue_f_nxt = '0;
    if (div_side.cmd == hrc_pkg::CMD_HSV2RGB) begin
      red_f_nxt = CB'(div_quo[0]);
      grn_f_nxt = CB'(div_quo[1]);
      blu_f_nxt = CB'(div_quo[2]);
    end else if (!div_side.blk) begin
      val_f_nxt = div_side.val;
      if (!div_side.gry) begin
        sat_f_nxt = CB'(div_quo[0]);
        if (div_side.hneg) begin
          if (magx >= MW'(hrc_pkg::HUE_NEG_LIM)) begin
            hue_f_nxt = HUW'(-hrc_pkg::HUE_NEG_LIM);
          end else begin
            hue_f_nxt = HUW'(-magx);
          end
        end else if (magx >= MW'(hrc_pkg::HUE_POS_LIM)) begin
          hue_f_nxt = HUW'(hrc_pkg::HUE_POS_LIM);
        end else begin
          hue_f_nxt = HUW'(magx);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (en_f) begin
      vf_r <= div_out_valid;
    end
    if (en_f) begin
      red_f_r <= red_f_nxt;
      grn_f_r <= grn_f_nxt;
      blu_f_r <= blu_f_nxt;
      sat_f_r <= sat_f_nxt;
      val_f_r <= val_f_nxt;
      hue_f_r <= hue_f_nxt;
    end
  end

  assign en_f = !vf_r || out_ch.ready;
  assign en_e = !ve_r || div_in_ready;
  assign en_d = !vd_r || en_e;
  assign en_c = !vc_r || en_d;
  assign en_b = !vb_r || en_c;
  assign en_a = !va_r || en_b;

  assign in_ch.ready      = en_a;
  assign out_ch.valid     = vf_r;
  assign out_ch.red_out   = red_f_r;
  assign out_ch.green_out = grn_f_r;
  assign out_ch.blue_out  = blu_f_r;
  assign out_ch.hue_out   = hue_f_r;
  assign out_ch.sat_out   = sat_f_r;
  assign out_ch.val_out   = val_f_r;

  logic rgb_nz, hsv_nz;

  assign rgb_nz = out_ch.red_out != '0 || out_ch.green_out != '0 || out_ch.blue_out != '0;
  assign hsv_nz = out_ch.hue_out != '0 || out_ch.sat_out != '0 || out_ch.val_out != '0;

  `HRC_ASSERT_NOW(a_idle_ready, !out_ch.valid, in_ch.ready)
  `HRC_ASSERT_NOW(a_rgb_excl, out_ch.valid && rgb_nz, !hsv_nz)
  `HRC_ASSERT_NOW(a_sat_needs_val, out_ch.valid && out_ch.sat_out != '0, out_ch.val_out != '0)
  `HRC_ASSERT_NEXT(a_stall_hold, out_ch.valid && !out_ch.ready, out_ch.valid)
endmodule
`default_nettype wire

// File: tb/tb_chan_if.sv
// Testbench notes: the block's channel interfaces come from RTL interface files.
`default_nettype none
package tb_pix_pkg;
  typedef struct packed {
    logic        cmd;
    logic [11:0] r;
    logic [11:0] g;
    logic [11:0] b;
    logic signed [13:0] h;
    logic [11:0] s;
    logic [11:0] v;
  } pixel_t;
endpackage
`default_nettype wire

// File: tb/tb.sv
// Self-checking stream test of the HSV/RGB colour converter against a bit-exact predictor.
`default_nettype none
module tb;
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hrc_in_if  #(.CB(12)) in_ch ();
  hrc_out_if #(.CB(12)) out_ch ();

  hsv_rgb_color_converter uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  localparam longint FULL = 360 * 16;
  localparam longint SIX  = FULL / 6;
  localparam longint MAXV = 4095;

  tb_pix_pkg::pixel_t pending_q[$];
  tb_pix_pkg::pixel_t colour_q[$];
  int     mismatches = 0;
  int     idle_cycles = 0;
  int     cycle_no = 0;
  int     hold_left = 0;
  bit     stim_done = 1'b0;
  bit     calm = 1'b0;
  bit     in_took = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [11:0] lane_level(longint hw, longint off, longint s, longint v);
    longint t, d, den;
    t = (hw + off) % FULL;
    d = t - FULL / 2;
    if (d < 0) d = -d;
    d -= SIX;
    if (d < 0) d = 0;
    if (d > SIX) d = SIX;
    den = MAXV * SIX;
    return 12'((v * (den - s * (SIX - d)) + den / 2) / den);
  endfunction

  function automatic tb_pix_pkg::pixel_t convert_pixel(tb_pix_pkg::pixel_t p);
    tb_pix_pkg::pixel_t o;
    longint hw, r, g, b, s, v, mx, mn, dl, base, n, num, hue;
    o = '0;
    r = longint'(p.r); g = longint'(p.g); b = longint'(p.b);
    s = longint'(p.s); v = longint'(p.v);
    if (p.cmd == hrc_pkg::CMD_HSV2RGB) begin
      hw = longint'(p.h) % FULL;
      if (hw < 0) hw += FULL;
      o.r = lane_level(hw, 0, s, v);
      o.g = lane_level(hw, 4 * SIX, s, v);
      o.b = lane_level(hw, 2 * SIX, s, v);
    end else begin
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      if (mx != 0) begin
        o.v = 12'(mx);
        dl = mx - mn;
        if (dl != 0) begin
          o.s = 12'((dl * MAXV * 2 + mx) / (2 * mx));
          if (mx == r) begin
            base = 0; n = g - b;
          end else if (mx == g) begin
            base = hrc_pkg::BASE_GREEN; n = b - r;
          end else begin
            base = hrc_pkg::BASE_BLUE; n = r - g;
          end
          num = (base * dl + hrc_pkg::SECT_SPAN * n) * FULL;
          if (num >= 0) begin
            hue = (2 * num + hrc_pkg::SECT_SCALE * dl) / (2 * hrc_pkg::SECT_SCALE * dl);
          end else begin
            hue = -((2 * (-num) + hrc_pkg::SECT_SCALE * dl) / (2 * hrc_pkg::SECT_SCALE * dl));
          end
          if (hue < -hrc_pkg::HUE_NEG_LIM) hue = -hrc_pkg::HUE_NEG_LIM;
          if (hue > hrc_pkg::HUE_POS_LIM) hue = hrc_pkg::HUE_POS_LIM;
          o.h = 14'(hue);
        end
      end
    end
    return o;
  endfunction

  function automatic tb_pix_pkg::pixel_t rand_pixel();
    tb_pix_pkg::pixel_t p;
    p.cmd = 1'($urandom_range(0, 1));
    p.r = 12'($urandom); p.g = 12'($urandom); p.b = 12'($urandom);
    p.h = 14'($urandom); p.s = 12'($urandom); p.v = 12'($urandom);
    case ($urandom_range(0, 7))
      0: p.g = p.r;
      1: begin p.g = p.r; p.b = p.r; end
      2: p.b = p.g;
      3: p.h = 14'(longint'($urandom_range(0, 15)) * SIX + longint'($urandom_range(0, 2)) - 1);
      default: ;
    endcase
    return p;
  endfunction

  function automatic tb_pix_pkg::pixel_t mk(logic c, int r, int g, int b, int h, int s, int v);
    tb_pix_pkg::pixel_t p;
    p.cmd = c; p.r = 12'(r); p.g = 12'(g); p.b = 12'(b);
    p.h = 14'(h); p.s = 12'(s); p.v = 12'(v);
    return p;
  endfunction

  initial begin
    pending_q.push_back(mk(hrc_pkg::CMD_RGB2HSV, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(hrc_pkg::CMD_RGB2HSV, 4095, 4095, 4095, 0, 0, 0));
    pending_q.push_back(mk(hrc_pkg::CMD_RGB2HSV, 2000, 2000, 2000, -1, 4095, 4095));
    pending_q.push_back(mk(hrc_pkg::CMD_RGB2HSV, 4095, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(hrc_pkg::CMD_RGB2HSV, 0, 4095, 0, 0, 0, 0));
    pending_q.push_back(mk(hrc_pkg::CMD_RGB2HSV, 0, 0, 4095, 0, 0, 0));
    pending_q.push_back(mk(hrc_pkg::CMD_RGB2HSV, 4095, 4095, 0, 0, 0, 0));
    pending_q.push_back(mk(hrc_pkg::CMD_RGB2HSV, 0, 4095, 4095, 0, 0, 0));
    pending_q.push_back(mk(hrc_pkg::CMD_RGB2HSV, 4095, 0, 4095, 0, 0, 0));
    pending_q.push_back(mk(hrc_pkg::CMD_RGB2HSV, 4095, 0, 1, 0, 0, 0));
    pending_q.push_back(mk(hrc_pkg::CMD_RGB2HSV, 1, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(hrc_pkg::CMD_HSV2RGB, 4095, 4095, 4095, 0, 4095, 4095));
    pending_q.push_back(mk(hrc_pkg::CMD_HSV2RGB, 0, 0, 0, -8192, 4095, 4095));
    pending_q.push_back(mk(hrc_pkg::CMD_HSV2RGB, 0, 0, 0, 8191, 4095, 4095));
    pending_q.push_back(mk(hrc_pkg::CMD_HSV2RGB, 0, 0, 0, -1, 0, 4095));
    pending_q.push_back(mk(hrc_pkg::CMD_HSV2RGB, 0, 0, 0, 5760, 4095, 0));
    pending_q.push_back(mk(hrc_pkg::CMD_HSV2RGB, 0, 0, 0, 960, 4095, 4095));
    pending_q.push_back(mk(hrc_pkg::CMD_HSV2RGB, 0, 0, 0, 1920, 2048, 4095));
    pending_q.push_back(mk(hrc_pkg::CMD_HSV2RGB, 0, 0, 0, 2880, 4095, 1));
    pending_q.push_back(mk(hrc_pkg::CMD_HSV2RGB, 0, 0, 0, -5760, 4095, 4095));
    for (int i = 0; i < 2000; i++) pending_q.push_back(rand_pixel());
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    wait (pending_q.size() == 0);
    stim_done = 1'b1;
  end

  always @(negedge clk) begin
    cycle_no <= cycle_no + 1;
    calm <= (cycle_no >= 600 && cycle_no < 1400);
  end

  initial begin
    in_ch.valid = 1'b0;
    {in_ch.cmd, in_ch.red_in, in_ch.green_in, in_ch.blue_in} = '0;
    {in_ch.hue_in, in_ch.sat_in, in_ch.val_in} = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    in_took <= rst_n && in_ch.valid && in_ch.ready;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_took) void'(pending_q.pop_front());
      if (in_ch.valid && !in_took) begin
        in_ch.valid <= 1'b1;
      end else if (pending_q.size() > 0 && (calm || $urandom_range(0, 99) >= 36)) begin
        in_ch.valid <= 1'b1;
        in_ch.cmd <= pending_q[0].cmd;
        in_ch.red_in <= pending_q[0].r;
        in_ch.green_in <= pending_q[0].g;
        in_ch.blue_in <= pending_q[0].b;
        in_ch.hue_in <= pending_q[0].h;
        in_ch.sat_in <= pending_q[0].s;
        in_ch.val_in <= pending_q[0].v;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (cycle_no == 200) hold_left <= 80;
    else if (hold_left > 0) hold_left <= hold_left - 1;
    out_ch.ready <= rst_n && hold_left == 0 && (calm || $urandom_range(0, 99) >= 36);
  end

  always @(posedge clk) begin
    tb_pix_pkg::pixel_t want, got, seen;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        seen = '{cmd: in_ch.cmd, r: in_ch.red_in, g: in_ch.green_in, b: in_ch.blue_in,
                 h: in_ch.hue_in, s: in_ch.sat_in, v: in_ch.val_in};
        colour_q.push_back(convert_pixel(seen));
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{cmd: 1'b0, r: out_ch.red_out, g: out_ch.green_out, b: out_ch.blue_out,
                h: out_ch.hue_out, s: out_ch.sat_out, v: out_ch.val_out};
        if (colour_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat %p", got);
        end else begin
          want = colour_q.pop_front();
          want.cmd = 1'b0;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (stim_done && colour_q.size() == 0);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && colour_q.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    wait (idle_cycles >= 2000);
    $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire

// File: hsv_rgb_color_converter.f
+incdir+rtl/core
rtl/core/hrc_pkg.sv
rtl/core/hrc_in_if.sv
rtl/core/hrc_out_if.sv
rtl/core/hrc_div.sv
rtl/core/hsv_rgb_color_converter.sv
tb/tb_chan_if.sv
tb/tb.sv
